### rtl/core/arpc_pkg.sv
// Package for the ARP cache with aging: operation and status codes,
// controller state type and controller/datapath command structs.
// No dependencies.
package arpc_pkg;

    localparam logic [1:0] OP_LEARN  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [2:0] STAT_MISS     = 3'd0;
    localparam logic [2:0] STAT_HIT      = 3'd1;
    localparam logic [2:0] STAT_UPDATED  = 3'd2;
    localparam logic [2:0] STAT_INSERTED = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;
    localparam logic [2:0] STAT_TICK     = 3'd5;

    localparam logic [15:0] LIFETIME_RESET = 16'd60000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
    } dp_status_t;

endpackage

### rtl/core/arp_cache_with_aging_core.sv
// Top level of the ARP cache with aging: joins the controller and the datapath.
// Depends on arpc_pkg, arpc_ctrl and arpc_datapath.
//
// The block keeps TABLE_ENTRIES mappings from IPv4 to MAC addresses. Each item
// (learn, lookup or aging tick) is handled by one pass over the table that reads
// one entry per cycle from the entry memories, followed by a drain step and a
// finish step, after which the next item can be taken. The finish step waits
// while a previous result is still waiting to be taken. A new item is taken
// while the last result waits in the output register. The table is empty after
// reset at once; there is no clearing pass. The lifetime register is written
// through cfg_wr_en and cfg_wr_data and applies to later learns only.
module arp_cache_with_aging_core
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] ip_address,
    input  logic [47:0] mac_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [47:0] found_mac,
    output logic [6:0]  expired_count
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    arpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    arpc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dp_status     (dp_status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .operation     (operation),
        .ip_address    (ip_address),
        .mac_address   (mac_address),
        .status        (status),
        .found_mac     (found_mac),
        .expired_count (expired_count)
    );

endmodule

### rtl/core/arpc_ctrl.sv
// Controller state machine for the ARP cache: sequences the table scan,
// the final commit and the output transfer handshake.
// Depends on arpc_pkg.
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (dp_status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("Result committed over an untaken result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SCAN))
        else $error("Accepted item did not start a scan.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("Result appeared outside the finish step.");

endmodule

### rtl/core/arpc_datapath.sv
// Datapath for the ARP cache: entry memories, valid bits, scan counter,
// match and free search, aging update and the result register.
// Depends on arpc_pkg.
module arpc_datapath
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  dp_status,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic [1:0]  operation,
    input  logic [31:0] ip_address,
    input  logic [47:0] mac_address,
    output logic [2:0]  status,
    output logic [47:0] found_mac,
    output logic [6:0]  expired_count
);

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);

    logic [31:0] ip_mem   [TABLE_ENTRIES];
    logic [47:0] mac_mem  [TABLE_ENTRIES];
    logic [15:0] life_mem [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [15:0]              lifetime_reg;
    logic [1:0]               op_reg;
    logic [31:0]              ip_reg;
    logic [47:0]              mac_reg;
    logic [IDX_W-1:0]         addr_reg;
    logic [IDX_W-1:0]         proc_idx_reg;
    logic                     proc_reg;
    logic [31:0]              ip_rd_reg;
    logic [47:0]              mac_rd_reg;
    logic [15:0]              life_rd_reg;
    logic                     hit_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [47:0]              hit_mac_reg;
    logic                     free_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [2:0]               status_reg;
    logic [47:0]              found_mac_reg;
    logic [6:0]               expired_reg;

    logic             entry_valid;
    logic             match;
    logic             age;
    logic             expire;
    logic             ip_we;
    logic             mac_we;
    logic             life_we;
    logic [IDX_W-1:0] wr_addr;
    logic [15:0]      life_wd;

    assign entry_valid = valid_reg[proc_idx_reg];
    assign match  = proc_reg && entry_valid && (ip_rd_reg == ip_reg);
    assign age    = proc_reg && (op_reg == OP_TICK) && entry_valid && (life_rd_reg != 16'd0);
    assign expire = age && (life_rd_reg == 16'd1);

    assign dp_status.scan_last = (addr_reg == IDX_W'(TABLE_ENTRIES - 1));

    always_comb
    begin
        ip_we   = 1'b0;
        mac_we  = 1'b0;
        life_we = 1'b0;
        wr_addr = proc_idx_reg;
        life_wd = life_rd_reg - 16'd1;
        if (age)
        begin
            life_we = 1'b1;
        end
        else if (cmd.commit && (op_reg == OP_LEARN))
        begin
            life_wd = lifetime_reg;
            if (hit_reg)
            begin
                wr_addr = hit_idx_reg;
                mac_we  = 1'b1;
                life_we = 1'b1;
            end
            else if (free_reg)
            begin
                wr_addr = free_idx_reg;
                ip_we   = 1'b1;
                mac_we  = 1'b1;
                life_we = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ip_we)
        begin
            ip_mem[wr_addr] <= ip_reg;
        end
        if (cmd.rd_en)
        begin
            ip_rd_reg <= ip_mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_we)
        begin
            mac_mem[wr_addr] <= mac_reg;
        end
        if (cmd.rd_en)
        begin
            mac_rd_reg <= mac_mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (life_we)
        begin
            life_mem[wr_addr] <= life_wd;
        end
        if (cmd.rd_en)
        begin
            life_rd_reg <= life_mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            lifetime_reg <= LIFETIME_RESET;
            addr_reg     <= '0;
            proc_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                lifetime_reg <= cfg_wr_data;
            end
            proc_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                addr_reg  <= '0;
                hit_reg   <= 1'b0;
                free_reg  <= 1'b0;
                count_reg <= '0;
            end
            else if (cmd.rd_en)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
            if (match && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (proc_reg && !entry_valid && !free_reg)
            begin
                free_reg <= 1'b1;
            end
            if (expire)
            begin
                valid_reg[proc_idx_reg] <= 1'b0;
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (cmd.commit && (op_reg == OP_LEARN) && !hit_reg && free_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            ip_reg  <= ip_address;
            mac_reg <= mac_address;
        end
        proc_idx_reg <= addr_reg;
        if (match && !hit_reg)
        begin
            hit_idx_reg <= proc_idx_reg;
            hit_mac_reg <= mac_rd_reg;
        end
        if (proc_reg && !entry_valid && !free_reg)
        begin
            free_idx_reg <= proc_idx_reg;
        end
        if (cmd.commit)
        begin
            found_mac_reg <= '0;
            expired_reg   <= '0;
            case (op_reg)
                OP_LEARN:
                begin
                    if (hit_reg)
                    begin
                        status_reg <= STAT_UPDATED;
                    end
                    else if (free_reg)
                    begin
                        status_reg <= STAT_INSERTED;
                    end
                    else
                    begin
                        status_reg <= STAT_FULL;
                    end
                end
                OP_LOOKUP:
                begin
                    if (hit_reg)
                    begin
                        status_reg    <= STAT_HIT;
                        found_mac_reg <= hit_mac_reg;
                    end
                    else
                    begin
                        status_reg <= STAT_MISS;
                    end
                end
                OP_TICK:
                begin
                    status_reg  <= STAT_TICK;
                    expired_reg <= 7'(count_reg);
                end
                default:
                begin
                    status_reg <= STAT_MISS;
                end
            endcase
        end
    end

    assign status        = status_reg;
    assign found_mac     = found_mac_reg;
    assign expired_count = expired_reg;

endmodule
